/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset
`define X86ALU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication whose consequent must hold in the next cycle
`define X86ALU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define X86ALU_ASSERT(lbl, clk, rst_n, prop, msg)
`define X86ALU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/x86alu_pkg.sv */
// ----------------------------------------------------------------------------
// x86alu_pkg
// Operation codes, flag bit positions and payload types of the 8086 ALU.
// ----------------------------------------------------------------------------
package x86alu_pkg;

  // Operation codes; codes 20 to 31 are not handled
  typedef enum logic [4:0] {
    OP_NOP  = 5'd0,
    OP_MOV  = 5'd1,
    OP_ADD  = 5'd2,
    OP_ADC  = 5'd3,
    OP_INC  = 5'd4,
    OP_SUB  = 5'd5,
    OP_SBB  = 5'd6,
    OP_DEC  = 5'd7,
    OP_NEG  = 5'd8,
    OP_CMP  = 5'd9,
    OP_MUL  = 5'd10,
    OP_IMUL = 5'd11,
    OP_NOT  = 5'd12,
    OP_AND  = 5'd13,
    OP_OR   = 5'd14,
    OP_XOR  = 5'd15,
    OP_TEST = 5'd16,
    OP_SHL  = 5'd17,
    OP_SHR  = 5'd18,
    OP_HLT  = 5'd19
  } op_e;

  // Flag bit positions in the flags word
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_P = 2;
  localparam int unsigned FL_A = 4;
  localparam int unsigned FL_Z = 6;
  localparam int unsigned FL_S = 7;
  localparam int unsigned FL_O = 11;

  localparam int unsigned FLAGS_W = 12;

  // Flags that the ALU ever writes
  localparam logic [FLAGS_W-1:0] FLAGS_USED = 12'h8D5;

  // Operand mask for byte operations
  localparam logic [15:0] BYTE_MASK = 16'h00FF;

  typedef struct packed {
    logic [4:0]  req_type;
    logic        word_size;
    logic [15:0] dest_value;
    logic [15:0] src_value;
  } req_t;

  typedef struct packed {
    logic [15:0]        result_low;
    logic [15:0]        result_high;
    logic               write_low;
    logic               write_high;
    logic [FLAGS_W-1:0] flags_out;
    logic               halt;
    logic               unimplemented;
  } rsp_t;

endpackage

/* rtl/core/x86alu_if.sv */
// ----------------------------------------------------------------------------
// x86alu_if
// Valid/ready channels for ALU requests and ALU results.
// ----------------------------------------------------------------------------

// Request channel
interface x86alu_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  req_type;
  logic        word_size;
  logic [15:0] dest_value;
  logic [15:0] src_value;

  modport source (output valid, output req_type, output word_size,
                  output dest_value, output src_value, input ready);
  modport sink   (input valid, input req_type, input word_size,
                  input dest_value, input src_value, output ready);
endinterface

// Result channel
interface x86alu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_low;
  logic [15:0] result_high;
  logic        write_low;
  logic        write_high;
  logic [11:0] flags_out;
  logic        halt;
  logic        unimplemented;

  modport source (output valid, output result_low, output result_high,
                  output write_low, output write_high, output flags_out,
                  output halt, output unimplemented, input ready);
  modport sink   (input valid, input result_low, input result_high,
                  input write_low, input write_high, input flags_out,
                  input halt, input unimplemented, output ready);
endinterface

/* rtl/core/x86alu_core.sv */
// ----------------------------------------------------------------------------
// x86alu_core
// Single-pass datapath: operands and current flags in, result and flags out.
// ----------------------------------------------------------------------------
module x86alu_core import x86alu_pkg::*; (
  input  req_t               req_i,
  input  logic [FLAGS_W-1:0] flags_i,
  output rsp_t               rsp_o
);

  // Update zero, sign and parity from a width-masked result
  function automatic logic [FLAGS_W-1:0] set_szp(input logic [FLAGS_W-1:0] f,
                                                 input logic [15:0] r,
                                                 input logic w);
    logic [FLAGS_W-1:0] fo;
    fo       = f;
    fo[FL_Z] = (r == 16'd0);
    fo[FL_S] = w ? r[15] : r[7];
    fo[FL_P] = ~^r[7:0];
    return fo;
  endfunction

  logic        w;
  logic [15:0] mask;
  logic [15:0] a;
  logic [15:0] b;
  logic        cin;
  op_e         op;

  // Operands masked to the operation width
  assign w    = req_i.word_size;
  assign mask = w ? 16'hFFFF : BYTE_MASK;
  assign a    = req_i.dest_value & mask;
  assign b    = req_i.src_value & mask;
  assign cin  = flags_i[FL_C];
  assign op   = op_e'(req_i.req_type);

  // Adder: add, adc, inc
  logic [15:0] add_b;
  logic        add_c;
  logic [16:0] sum;
  logic [15:0] sum_x;

  assign add_b = (op == OP_INC) ? 16'd1 : b;
  assign add_c = (op == OP_ADC) ? cin : 1'b0;
  assign sum   = {1'b0, a} + {1'b0, add_b} + {16'd0, add_c};
  assign sum_x = a ^ add_b ^ sum[15:0];

  // Subtractor: sub, sbb, dec, neg, cmp; the top bit is the borrow
  logic [15:0] sub_x;
  logic [15:0] sub_y;
  logic        sub_c;
  logic [17:0] diff;
  logic [15:0] diff_x;

  assign sub_x  = (op == OP_NEG) ? 16'd0 : a;
  assign sub_y  = (op == OP_DEC) ? 16'd1 : ((op == OP_NEG) ? a : b);
  assign sub_c  = (op == OP_SBB) ? cin : 1'b0;
  assign diff   = {2'b00, sub_x} - {2'b00, sub_y} - {17'd0, sub_c};
  assign diff_x = sub_x ^ sub_y ^ diff[15:0];

  // Multiplier: sign-extend for imul, zero-extend for mul
  logic               sa;
  logic               sb;
  logic signed [16:0] ma;
  logic signed [16:0] mb;
  logic signed [33:0] prod;
  logic [31:0]        p;
  logic               mul_ov;
  logic               imul_ov;

  assign sa      = (op == OP_IMUL) && (w ? a[15] : a[7]);
  assign sb      = (op == OP_IMUL) && (w ? b[15] : b[7]);
  assign ma      = w ? $signed({sa, a}) : $signed({{9{sa}}, a[7:0]});
  assign mb      = w ? $signed({sb, b}) : $signed({{9{sb}}, b[7:0]});
  assign prod    = ma * mb;
  assign p       = prod[31:0];
  assign mul_ov  = w ? (p[31:16] != 16'd0) : (p[15:8] != 8'd0);
  assign imul_ov = w ? !((&p[31:15]) || (~|p[31:15]))
                     : !((&p[15:7]) || (~|p[15:7]));

  // Shifter: count is the low byte of the source, not masked by width
  logic [7:0]  cnt;
  logic [31:0] shl_wide;
  logic [15:0] shr_prev;

  assign cnt      = req_i.src_value[7:0];
  assign shl_wide = {16'd0, a} << cnt;
  assign shr_prev = a >> (cnt - 8'd1);

  // Select the result and the flags for the operation
  always_comb begin
    logic [FLAGS_W-1:0] f;
    logic [15:0]        r;
    logic [15:0]        hi;
    logic               wl;
    logic               wh;
    logic               hlt;
    logic               unimp;
    logic               cf;

    f     = flags_i;
    r     = 16'd0;
    hi    = 16'd0;
    wl    = 1'b0;
    wh    = 1'b0;
    hlt   = 1'b0;
    unimp = 1'b0;
    cf    = 1'b0;

    case (op)
      OP_NOP: begin
      end
      OP_MOV: begin
        r  = b;
        wl = 1'b1;
      end
      OP_ADD, OP_ADC, OP_INC: begin
        r  = sum[15:0] & mask;
        wl = 1'b1;
        if (op != OP_INC) begin
          f[FL_C] = w ? sum[16] : sum[8];
        end
        f[FL_A] = sum_x[FL_A];
        f[FL_O] = w ? (~(a[15] ^ add_b[15]) & (a[15] ^ sum[15]))
                    : (~(a[7] ^ add_b[7]) & (a[7] ^ sum[7]));
        f = set_szp(f, r, w);
      end
      OP_SUB, OP_SBB, OP_DEC, OP_NEG, OP_CMP: begin
        r  = diff[15:0] & mask;
        wl = (op != OP_CMP);
        if (op != OP_DEC) begin
          f[FL_C] = diff[17];
        end
        f[FL_A] = diff_x[FL_A];
        f[FL_O] = w ? ((sub_x[15] ^ sub_y[15]) & (sub_x[15] ^ diff[15]))
                    : ((sub_x[7] ^ sub_y[7]) & (sub_x[7] ^ diff[7]));
        f = set_szp(f, r, w);
      end
      OP_MUL, OP_IMUL: begin
        r       = p[15:0];
        hi      = p[31:16];
        wl      = 1'b1;
        wh      = w;
        f[FL_C] = (op == OP_MUL) ? mul_ov : imul_ov;
        f[FL_O] = (op == OP_MUL) ? mul_ov : imul_ov;
      end
      OP_NOT: begin
        r  = ~a & mask;
        wl = 1'b1;
      end
      OP_AND, OP_OR, OP_XOR, OP_TEST: begin
        if (op == OP_OR) begin
          r = a | b;
        end else if (op == OP_XOR) begin
          r = a ^ b;
        end else begin
          r = a & b;
        end
        wl      = (op != OP_TEST);
        f[FL_C] = 1'b0;
        f[FL_O] = 1'b0;
        f = set_szp(f, r, w);
      end
      OP_SHL, OP_SHR: begin
        wl = 1'b1;
        if (cnt == 8'd0) begin
          r = a;
        end else if (op == OP_SHL) begin
          r       = shl_wide[15:0] & mask;
          cf      = w ? shl_wide[16] : shl_wide[8];
          f[FL_O] = (w ? r[15] : r[7]) ^ cf;
          f[FL_C] = cf;
          f = set_szp(f, r, w);
        end else begin
          r       = {1'b0, shr_prev[15:1]};
          f[FL_O] = w ? shr_prev[15] : shr_prev[7];
          f[FL_C] = shr_prev[0];
          f = set_szp(f, r, w);
        end
      end
      OP_HLT: begin
        hlt = 1'b1;
      end
      default: begin
        unimp = 1'b1;
      end
    endcase

    rsp_o.result_low    = wl ? r : 16'd0;
    rsp_o.result_high   = wh ? hi : 16'd0;
    rsp_o.write_low     = wl;
    rsp_o.write_high    = wh;
    rsp_o.flags_out     = f;
    rsp_o.halt          = hlt;
    rsp_o.unimplemented = unimp;
  end

endmodule

/* rtl/core/x86_16bit_alu_with_flags_top.sv */
// ----------------------------------------------------------------------------
// x86_16bit_alu_with_flags_top
// 8086-style ALU with flags register, input register and result register.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Payload                                        | Handshake
//  req_i    | in  | req_type, word_size, dest_value, src_value     | valid/ready
//  rsp_o    | out | result_low/high, write_low/high, flags_out,    | valid/ready
//           |     | halt, unimplemented                            |
//
//  One transaction per cycle sustained while rsp_o is ready. A taken request
//  waits in the input register and moves into the result register once that
//  is empty or its result is accepted; the result is offered from there.
//  Flags update as an item enters the result register; the next item sees them.
//  Reset clears the flags word and both valid bits.
//  A stalled result holds; ready drops only while both registers are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module x86_16bit_alu_with_flags_top import x86alu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  x86alu_req_if.sink          req_i,
  x86alu_rsp_if.source        rsp_o
);

  logic               s1_valid_q;
  logic               s1_valid_d;
  req_t               s1_req_q;
  logic               rsp_valid_q;
  logic               rsp_valid_d;
  rsp_t               rsp_q;
  rsp_t               core_rsp;
  logic [FLAGS_W-1:0] flags_q;
  logic [FLAGS_W-1:0] flags_d;
  logic               advance;
  logic               take;

  // Move the input register into the result register when it is free
  assign advance     = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign take        = req_i.valid && req_i.ready;

  x86alu_core u_core (
    .req_i   (s1_req_q),
    .flags_i (flags_q),
    .rsp_o   (core_rsp)
  );

  // Next-state for valid bits and flags
  always_comb begin
    s1_valid_d  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    rsp_valid_d = advance ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);
    flags_d     = advance ? core_rsp.flags_out : flags_q;
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      rsp_valid_q <= rsp_valid_d;
      flags_q     <= flags_d;
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_req_q.req_type   <= req_i.req_type;
      s1_req_q.word_size  <= req_i.word_size;
      s1_req_q.dest_value <= req_i.dest_value;
      s1_req_q.src_value  <= req_i.src_value;
    end
    if (advance) begin
      rsp_q <= core_rsp;
    end
  end

  // Drive the result channel
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.result_low    = rsp_q.result_low;
  assign rsp_o.result_high   = rsp_q.result_high;
  assign rsp_o.write_low     = rsp_q.write_low;
  assign rsp_o.write_high    = rsp_q.write_high;
  assign rsp_o.flags_out     = rsp_q.flags_out;
  assign rsp_o.halt          = rsp_q.halt;
  assign rsp_o.unimplemented = rsp_q.unimplemented;

  // Assertions
  `X86ALU_ASSERT_NEXT(a_flags_hold, clk_i, rst_ni, !advance, $stable(flags_q), "flags changed without an advancing transaction")
  `X86ALU_ASSERT(a_flags_match, clk_i, rst_ni, !rsp_valid_q || (rsp_q.flags_out == flags_q), "pending result flags differ from flags register")
  `X86ALU_ASSERT(a_flags_used, clk_i, rst_ni, (flags_q & ~FLAGS_USED) == '0, "flag bit outside the ALU set is on")
  `X86ALU_ASSERT(a_high_needs_low, clk_i, rst_ni, !rsp_valid_q || !rsp_q.write_high || rsp_q.write_low, "DX write without AX write")
  `X86ALU_ASSERT_NEXT(a_unimp_flags, clk_i, rst_ni, advance && core_rsp.unimplemented, flags_q == $past(flags_q), "unimplemented code changed flags")

endmodule
